// ===== hw/rtl/nearest_neighbor_image_scaler_top_macros.svh =====
// Assertion macros for the nearest-neighbour scaler; clk and rst_n must be in scope.
`ifndef NEAREST_NEIGHBOR_IMAGE_SCALER_TOP_MACROS_SVH
`define NEAREST_NEIGHBOR_IMAGE_SCALER_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define NNS_ASSERT_HOLDS(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define NNS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/nns_pkg.sv =====
// Package: sizes, types and helpers shared by the nearest-neighbour scaler.
`default_nettype none

package nns_pkg;

    localparam int MAX_SIDE      = 256;
    localparam int CHANNEL_BITS  = 16;
    localparam int NUM_CHANNELS  = 4;
    localparam int PIXEL_BITS    = CHANNEL_BITS * NUM_CHANNELS;
    localparam int POS_BITS      = $clog2(MAX_SIDE);
    localparam int SIDE_BITS     = POS_BITS + 1;
    localparam int STORE_DEPTH   = MAX_SIDE * MAX_SIDE;
    localparam int ADDR_BITS     = 2 * POS_BITS;
    localparam int SIZE_BITS     = 2 * SIDE_BITS;
    localparam int PROD_BITS     = 2 * SIDE_BITS - 1;
    localparam int DEN_BITS      = SIDE_BITS + 1;
    localparam int QUO_BITS      = POS_BITS;
    localparam int STEP_BITS     = $clog2(QUO_BITS);
    localparam int DIV_LANES     = 2;
    localparam int QUEUE_DEPTH   = 2;
    localparam int QPTR_BITS     = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS     = QPTR_BITS + 1;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_RESET     = 256;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_SRC_WIDTH,
        CFG_SRC_HEIGHT,
        CFG_DST_WIDTH,
        CFG_DST_HEIGHT
    } cfg_reg_t;

    typedef enum logic [1:0] {
        FS_IDLE,
        FS_PREP,
        FS_DIV,
        FS_PUSH
    } front_state_t;

    // One queued operation: a store write (load) or a store read (emit).
    typedef struct packed {
        logic                  emit;
        logic                  last;
        logic [ADDR_BITS-1:0]  addr;
        logic [PIXEL_BITS-1:0] data;
    } op_t;

    // Zero counts as one, anything above the largest side saturates.
    function automatic logic [SIDE_BITS-1:0] eff_size(input logic [SIDE_BITS-1:0] v);
        logic [SIDE_BITS-1:0] r;
        if (v == '0)
        begin
            r = SIDE_BITS'(1);
        end
        else if (v > SIDE_BITS'(MAX_SIDE))
        begin
            r = SIDE_BITS'(MAX_SIDE);
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/nns_ram.sv =====
// Generic simple dual-port RAM with registered read.
`default_nettype none

module nns_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/nns_div.sv =====
// Two-lane restoring divider, one quotient bit per lane per cycle.
`default_nettype none

module nns_div import nns_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [PROD_BITS-1:0] num_x,
    input  logic [PROD_BITS-1:0] num_y,
    input  logic [DEN_BITS-1:0]  den_x,
    input  logic [DEN_BITS-1:0]  den_y,
    output logic                 done,
    output logic [QUO_BITS-1:0]  q_x,
    output logic [QUO_BITS-1:0]  q_y
);

    logic [PROD_BITS-1:0] num_in [DIV_LANES];
    logic [DEN_BITS-1:0]  den_in [DIV_LANES];
    logic [PROD_BITS-1:0] rem_reg [DIV_LANES];
    logic [PROD_BITS-1:0] rem_next [DIV_LANES];
    logic [PROD_BITS-1:0] dsh_reg [DIV_LANES];
    logic [PROD_BITS-1:0] dsh_next [DIV_LANES];
    logic [QUO_BITS-1:0]  quo_reg [DIV_LANES];
    logic [QUO_BITS-1:0]  quo_next [DIV_LANES];
    logic [STEP_BITS-1:0] step_reg, step_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;

    assign num_in[0] = num_x;
    assign num_in[1] = num_y;
    assign den_in[0] = den_x;
    assign den_in[1] = den_y;

    // Quotient is known to fit QUO_BITS, so the divisor starts shifted by QUO_BITS-1.
    always_comb
    begin
        logic ge;
        for (int l = 0; l < DIV_LANES; l++)
        begin
            rem_next[l] = rem_reg[l];
            dsh_next[l] = dsh_reg[l];
            quo_next[l] = quo_reg[l];
            ge          = rem_reg[l] >= dsh_reg[l];
            if (start)
            begin
                rem_next[l] = num_in[l];
                dsh_next[l] = {den_in[l], {(QUO_BITS-1){1'b0}}};
                quo_next[l] = '0;
            end
            else if (busy_reg)
            begin
                rem_next[l] = ge ? (rem_reg[l] - dsh_reg[l]) : rem_reg[l];
                dsh_next[l] = dsh_reg[l] >> 1;
                quo_next[l] = {quo_reg[l][QUO_BITS-2:0], ge};
            end
        end
    end

    always_comb
    begin
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            step_next = STEP_BITS'(QUO_BITS - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            step_next = step_reg - STEP_BITS'(1);
            if (step_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int l = 0; l < DIV_LANES; l++)
        begin
            rem_reg[l] <= rem_next[l];
            dsh_reg[l] <= dsh_next[l];
            quo_reg[l] <= quo_next[l];
        end
    end

    assign done = done_reg;
    assign q_x  = quo_reg[0];
    assign q_y  = quo_reg[1];

endmodule

`default_nettype wire

// ===== hw/rtl/nns_front.sv =====
// Front end: config registers, request intake, load addressing and source mapping.
`default_nettype none

module nns_front import nns_pkg::*; (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_write,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [SIDE_BITS-1:0]      cfg_data,
    input  logic                      req_valid,
    output logic                      req_ready,
    input  logic                      req_type,
    input  logic [CHANNEL_BITS-1:0]   in_red,
    input  logic [CHANNEL_BITS-1:0]   in_green,
    input  logic [CHANNEL_BITS-1:0]   in_blue,
    input  logic [CHANNEL_BITS-1:0]   in_alpha,
    output logic                      q_push,
    output op_t                       q_push_op,
    input  logic                      q_full
);

    front_state_t         state_reg, state_next;
    logic [SIDE_BITS-1:0] sw_reg, sh_reg, dw_reg, dh_reg;
    logic [ADDR_BITS-1:0] load_addr_reg;
    logic [POS_BITS-1:0]  col_reg, row_reg;
    logic [PROD_BITS-1:0] prod_x_reg, prod_y_reg;
    logic                 last_reg;

    logic [SIDE_BITS-1:0]           sw, sh, dw, dh;
    logic [SIZE_BITS-1:0]           frame_size;
    logic [ADDR_BITS-1:0]           load_cur, load_nxt;
    logic [ADDR_BITS:0]             load_inc;
    logic [POS_BITS-1:0]            col_cur, row_cur, col_nxt, row_nxt;
    logic [SIDE_BITS-1:0]           col_inc, row_inc;
    logic                           col_wrap, row_wrap;
    logic                           last_cur;
    logic [2*SIDE_BITS-1:0]         prod_x_full, prod_y_full;
    logic [PROD_BITS-1:0]           dw_ext, dh_ext, num_x, num_y;
    logic [QUO_BITS-1:0]            q_x, q_y;
    logic [POS_BITS+SIDE_BITS-1:0]  pix_addr_full;
    logic                           accept, div_start, div_done;

    assign sw = eff_size(sw_reg);
    assign sh = eff_size(sh_reg);
    assign dw = eff_size(dw_reg);
    assign dh = eff_size(dh_reg);

    assign accept = req_valid && req_ready;

    // Load address: restarts if the frame shrank, wraps after the last pixel.
    assign frame_size = {{SIDE_BITS{1'b0}}, sw} * {{SIDE_BITS{1'b0}}, sh};
    assign load_cur   = ({{(SIZE_BITS-ADDR_BITS){1'b0}}, load_addr_reg} >= frame_size)
                      ? '0 : load_addr_reg;
    assign load_inc   = {1'b0, load_cur} + (ADDR_BITS+1)'(1);
    assign load_nxt   = ({{(SIZE_BITS-ADDR_BITS-1){1'b0}}, load_inc} >= frame_size)
                      ? '0 : load_inc[ADDR_BITS-1:0];

    // Destination position, with the out-of-frame restart.
    assign col_cur  = ({1'b0, col_reg} >= dw) ? '0 : col_reg;
    assign row_cur  = ({1'b0, row_reg} >= dh) ? '0 : row_reg;
    assign col_inc  = {1'b0, col_cur} + SIDE_BITS'(1);
    assign row_inc  = {1'b0, row_cur} + SIDE_BITS'(1);
    assign col_wrap = col_inc >= dw;
    assign row_wrap = row_inc >= dh;
    assign col_nxt  = col_wrap ? '0 : col_inc[POS_BITS-1:0];
    assign row_nxt  = col_wrap ? (row_wrap ? '0 : row_inc[POS_BITS-1:0]) : row_cur;
    assign last_cur = ({1'b0, col_cur} == (dw - SIDE_BITS'(1)))
                   && ({1'b0, row_cur} == (dh - SIDE_BITS'(1)));

    // (2x+1)*src for each axis
    assign prod_x_full = {{SIDE_BITS{1'b0}}, col_cur, 1'b1} * {{SIDE_BITS{1'b0}}, sw};
    assign prod_y_full = {{SIDE_BITS{1'b0}}, row_cur, 1'b1} * {{SIDE_BITS{1'b0}}, sh};

    // Numerator clamps at zero; quotient then never exceeds src-1.
    assign dw_ext = {{(PROD_BITS-SIDE_BITS){1'b0}}, dw};
    assign dh_ext = {{(PROD_BITS-SIDE_BITS){1'b0}}, dh};
    assign num_x  = (prod_x_reg >= dw_ext) ? (prod_x_reg - dw_ext) : '0;
    assign num_y  = (prod_y_reg >= dh_ext) ? (prod_y_reg - dh_ext) : '0;

    nns_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num_x (num_x),
        .num_y (num_y),
        .den_x ({dw, 1'b0}),
        .den_y ({dh, 1'b0}),
        .done  (div_done),
        .q_x   (q_x),
        .q_y   (q_y)
    );

    assign pix_addr_full = {{SIDE_BITS{1'b0}}, q_y} * {{POS_BITS{1'b0}}, sw}
                         + {{SIDE_BITS{1'b0}}, q_x};

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            FS_IDLE:
            begin
                if (accept && req_type)
                begin
                    state_next = FS_PREP;
                end
            end
            FS_PREP:
            begin
                state_next = FS_DIV;
            end
            FS_DIV:
            begin
                if (div_done)
                begin
                    state_next = FS_PUSH;
                end
            end
            FS_PUSH:
            begin
                if (!q_full)
                begin
                    state_next = FS_IDLE;
                end
            end
            default:
            begin
                state_next = FS_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req_ready      = 1'b0;
        div_start      = 1'b0;
        q_push         = 1'b0;
        q_push_op.emit = 1'b0;
        q_push_op.last = last_reg;
        q_push_op.addr = load_cur;
        q_push_op.data = {in_alpha, in_blue, in_green, in_red};
        case (state_reg)
            FS_IDLE:
            begin
                req_ready = !q_full;
                q_push    = accept && !req_type;
            end
            FS_PREP:
            begin
                div_start = 1'b1;
            end
            FS_DIV:
            begin
                div_start = 1'b0;
            end
            FS_PUSH:
            begin
                q_push         = !q_full;
                q_push_op.emit = 1'b1;
                q_push_op.addr = pix_addr_full[ADDR_BITS-1:0];
                q_push_op.data = '0;
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= FS_IDLE;
            sw_reg        <= SIDE_BITS'(CFG_RESET);
            sh_reg        <= SIDE_BITS'(CFG_RESET);
            dw_reg        <= SIDE_BITS'(CFG_RESET);
            dh_reg        <= SIDE_BITS'(CFG_RESET);
            load_addr_reg <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_write)
            begin
                case (cfg_reg_t'(cfg_index))
                    CFG_SRC_WIDTH:  sw_reg <= cfg_data;
                    CFG_SRC_HEIGHT: sh_reg <= cfg_data;
                    CFG_DST_WIDTH:  dw_reg <= cfg_data;
                    CFG_DST_HEIGHT: dh_reg <= cfg_data;
                    default:        sw_reg <= sw_reg;
                endcase
            end
            if (accept && !req_type)
            begin
                load_addr_reg <= load_nxt;
            end
            if (accept && req_type)
            begin
                col_reg <= col_nxt;
                row_reg <= row_nxt;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && req_type)
        begin
            prod_x_reg <= prod_x_full[PROD_BITS-1:0];
            prod_y_reg <= prod_y_full[PROD_BITS-1:0];
            last_reg   <= last_cur;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/nns_fifo.sv =====
// Short operation queue between front end and back end.
`default_nettype none

module nns_fifo import nns_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  op_t  push_op,
    output logic full,
    input  logic pop,
    output op_t  head,
    output logic empty
);

    op_t                  slot_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_BITS-1:0] count_reg;
    logic                 do_push, do_pop;

    assign full    = count_reg == QCNT_BITS'(QUEUE_DEPTH);
    assign empty   = count_reg == '0;
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_BITS'(QUEUE_DEPTH - 1))
                            ? '0 : wr_ptr_reg + QPTR_BITS'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_BITS'(QUEUE_DEPTH - 1))
                            ? '0 : rd_ptr_reg + QPTR_BITS'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + QCNT_BITS'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - QCNT_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/nns_back.sv =====
// Back end: frame store access and output word register.
`default_nettype none

module nns_back import nns_pkg::*; (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    q_empty,
    input  op_t                     q_head,
    output logic                    q_pop,
    output logic                    pix_valid,
    input  logic                    pix_ready,
    output logic [CHANNEL_BITS-1:0] out_red,
    output logic [CHANNEL_BITS-1:0] out_green,
    output logic [CHANNEL_BITS-1:0] out_blue,
    output logic [CHANNEL_BITS-1:0] out_alpha,
    output logic                    frame_last
);

    logic                  pix_valid_reg, pix_valid_next;
    logic                  last_reg;
    logic                  store_we, store_re;
    logic [PIXEL_BITS-1:0] store_rdata;

    // Loads drain freely; a read goes only when the output word is free or leaving.
    assign q_pop    = !q_empty && (!q_head.emit || !pix_valid_reg || pix_ready);
    assign store_we = q_pop && !q_head.emit;
    assign store_re = q_pop && q_head.emit;

    nns_ram #(
        .WIDTH (PIXEL_BITS),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (store_we),
        .waddr (q_head.addr),
        .wdata (q_head.data),
        .re    (store_re),
        .raddr (q_head.addr),
        .rdata (store_rdata)
    );

    always_comb
    begin
        pix_valid_next = pix_valid_reg;
        if (store_re)
        begin
            pix_valid_next = 1'b1;
        end
        else if (pix_ready)
        begin
            pix_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_valid_reg <= 1'b0;
        end
        else
        begin
            pix_valid_reg <= pix_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (store_re)
        begin
            last_reg <= q_head.last;
        end
    end

    // RAM read register holds the word until the next read.
    assign pix_valid  = pix_valid_reg;
    assign frame_last = last_reg;
    assign out_red    = store_rdata[CHANNEL_BITS-1:0];
    assign out_green  = store_rdata[2*CHANNEL_BITS-1:CHANNEL_BITS];
    assign out_blue   = store_rdata[3*CHANNEL_BITS-1:2*CHANNEL_BITS];
    assign out_alpha  = store_rdata[4*CHANNEL_BITS-1:3*CHANNEL_BITS];

endmodule

`default_nettype wire

// ===== hw/rtl/nearest_neighbor_image_scaler_top.sv =====
// Top level of the nearest-neighbour image scaler.
`default_nettype none

`include "nearest_neighbor_image_scaler_top_macros.svh"

// Nearest-neighbour image scaler with pixel-centre sampling. Each request word is
// either a load (req_type 0) or an emit (req_type 1). A load writes one RGBA pixel
// into the frame store in raster order and gives no output. An emit returns the
// source pixel chosen for the next destination pixel, with frame_last set on the
// final pixel of the destination frame. Loads are taken back to back while the
// queue has room. After an emit is taken, the request side stays blocked until
// its mapping has pushed the store read:
//   - the accepting cycle forms (2x+1)*src per axis;
//   - a prep state subtracts the destination size and starts the shared two-lane
//     restoring divider;
//   - a divide state waits out the divider's eight quotient bits and its done flag;
//   - a push state forms the store address and pushes the read.
// It waits longer while the queue is full. The store read and the output register
// follow in the back end, behind a two-entry queue. A waiting output word does not
// stop new requests from being taken until that queue fills. The 64K x 64 frame
// store has no reset and no clearing pass: every entry must be loaded before it is
// selected. Size registers treat 0 as 1 and saturate at 256; write them only while
// the block is idle.
module nearest_neighbor_image_scaler_top import nns_pkg::*; (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_write,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [SIDE_BITS-1:0]      cfg_data,
    input  logic                      req_valid,
    output logic                      req_ready,
    input  logic                      req_type,
    input  logic [CHANNEL_BITS-1:0]   in_red,
    input  logic [CHANNEL_BITS-1:0]   in_green,
    input  logic [CHANNEL_BITS-1:0]   in_blue,
    input  logic [CHANNEL_BITS-1:0]   in_alpha,
    output logic                      pix_valid,
    input  logic                      pix_ready,
    output logic [CHANNEL_BITS-1:0]   out_red,
    output logic [CHANNEL_BITS-1:0]   out_green,
    output logic [CHANNEL_BITS-1:0]   out_blue,
    output logic [CHANNEL_BITS-1:0]   out_alpha,
    output logic                      frame_last
);

    // queue handshake between the two halves
    logic q_push, q_full, q_pop, q_empty;
    op_t  q_push_op, q_head;

    // front: config, intake, load address, source column/row mapping
    nns_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_type  (req_type),
        .in_red    (in_red),
        .in_green  (in_green),
        .in_blue   (in_blue),
        .in_alpha  (in_alpha),
        .q_push    (q_push),
        .q_push_op (q_push_op),
        .q_full    (q_full)
    );

    // in-order queue keeps every store write ahead of later reads
    nns_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .push_op (q_push_op),
        .full    (q_full),
        .pop     (q_pop),
        .head    (q_head),
        .empty   (q_empty)
    );

    // back: frame store and output word
    nns_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_head     (q_head),
        .q_pop      (q_pop),
        .pix_valid  (pix_valid),
        .pix_ready  (pix_ready),
        .out_red    (out_red),
        .out_green  (out_green),
        .out_blue   (out_blue),
        .out_alpha  (out_alpha),
        .frame_last (frame_last)
    );

    // no word may be lost at the queue
    `NNS_ASSERT_HOLDS(a_no_push_when_full, q_full, !q_push, "queue written while full")
    // an emit occupies the front end for its whole mapping
    `NNS_ASSERT_NEXT(a_emit_holds_front, req_valid && req_ready && req_type, !req_ready,
                     "request taken during emit mapping")
    // a store read only when the output word can take its data
    `NNS_ASSERT_HOLDS(a_read_slot_free, q_pop && q_head.emit, !pix_valid || pix_ready,
                      "store read would overwrite a pending output word")

endmodule

`default_nettype wire
